>>> hw/rtl/sgfa_pkg.sv
// Shared types and constants for the Simpson grid field averager.
`timescale 1ns / 1ps
`default_nettype none

package sgfa_pkg;

  localparam int unsigned SMP_W      = 32;
  localparam int unsigned SQ_OUT_W   = 48;
  localparam int unsigned ACC_W      = 64;
  localparam int unsigned PTS_W      = 9;
  localparam int unsigned IDX_W      = 8;
  localparam int unsigned MAX_POINTS = 256;
  localparam int unsigned WFRAC      = 30;
  localparam int unsigned WT_W       = 31;
  localparam int unsigned NUM_W      = 33;
  localparam int unsigned DEN_W      = 10;
  localparam int unsigned CNT_W      = $clog2(NUM_W + 1);
  localparam int unsigned CFG_IDX_W  = 2;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_POINTS_X = 2'd0,
    REG_POINTS_Y = 2'd1,
    REG_POINTS_Z = 2'd2
  } sgfa_reg_e;

  // sequencer states
  typedef enum logic [3:0] {
    S_WSTART,
    S_WWAIT,
    S_IDLE,
    S_LOAD,
    S_SQ,
    S_SQR,
    S_ML,
    S_MH,
    S_COMB,
    S_TERM,
    S_ACC,
    S_LEVEL,
    S_EMIT
  } sgfa_state_e;

  typedef struct packed {
    logic signed [SMP_W-1:0] sample_x;
    logic signed [SMP_W-1:0] sample_y;
    logic signed [SMP_W-1:0] sample_z;
  } in_t;

  typedef struct packed {
    logic signed [SMP_W-1:0]  mean_bx;
    logic signed [SMP_W-1:0]  mean_by;
    logic signed [SMP_W-1:0]  mean_bz;
    logic [SQ_OUT_W-1:0]      meansq_bx;
    logic [SQ_OUT_W-1:0]      meansq_by;
    logic [SQ_OUT_W-1:0]      meansq_bz;
    logic signed [SMP_W-1:0]  first_plane_bx;
    logic signed [SMP_W-1:0]  last_plane_bx;
  } out_t;

  // weight divider status
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

`default_nettype wire

>>> hw/rtl/simpson_grid_field_average.sv
// Top level of the Simpson grid field averager: sequencer, accumulators, result register.
`timescale 1ns / 1ps
`default_nettype none

// Takes three-component Q16.16 field samples in raster order (Z fastest, then Y, then X)
// over a grid of points_x by points_y by points_z points and, after the last sample,
// gives one request with the Simpson-weighted means, mean squares and the first and
// last X-plane averages of Bx. One 32x32 multiplier is shared by all work under a
// sequencer, one sample at a time: an ordinary sample takes three squares plus six
// weighted sums at two multiplier passes each, a sample closing a Z row a further
// six weighted sums, one closing a Y plane six more, and the last sample of the grid
// then loads the result register. After reset and after every register write the block
// computes its nine axis weights with a bit-serial divider and takes no sample meanwhile.
// A register write clears the running grid.
module simpson_grid_field_average (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  sgfa_pkg::in_t                      in_data_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output sgfa_pkg::out_t                     out_data_o,
  input  logic                               cfg_we_i,
  input  logic [sgfa_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [sgfa_pkg::PTS_W-1:0]         cfg_data_i
);

  localparam int unsigned AW = sgfa_pkg::ACC_W;

  sgfa_pkg::sgfa_state_e state_q, state_d;

  logic [sgfa_pkg::PTS_W-1:0]      pts_q [3];
  logic [sgfa_pkg::IDX_W-1:0]      idx_q [3];
  logic signed [sgfa_pkg::SMP_W-1:0] smp_q [3];
  logic signed [AW-1:0] row_sum_q [3];
  logic signed [AW-1:0] plane_sum_q [3];
  logic signed [AW-1:0] vol_sum_q [3];
  logic [AW-1:0]        row_sq_q [3];
  logic [AW-1:0]        plane_sq_q [3];
  logic [AW-1:0]        vol_sq_q [3];
  logic signed [AW-1:0] first_q, last_q;
  logic [sgfa_pkg::WT_W-1:0] wt_q [9];

  logic [1:0] level_q, wax_q, wk_q;
  logic [2:0] job_q;
  logic [1:0] comp;
  logic       kind_sq;

  logic [AW-1:0]              opnd_q, pl_q, term_q;
  logic                       neg_q;
  logic [sgfa_pkg::WT_W-1:0]  w_q;
  logic [95:0]                prod_q;

  sgfa_pkg::out_t out_q;
  logic           out_valid_q;

  logic       cfg_hit;
  logic       emit_go;
  logic       z_more, y_more, x_more;

  // job decode: component and plain or squared sum
  assign comp    = job_q[2:1];
  assign kind_sq = job_q[0];

  assign cfg_hit = cfg_we_i && (cfg_idx_i == sgfa_pkg::REG_POINTS_X ||
                                cfg_idx_i == sgfa_pkg::REG_POINTS_Y ||
                                cfg_idx_i == sgfa_pkg::REG_POINTS_Z);

  assign z_more = (9'(idx_q[2]) + 9'd1) < pts_q[2];
  assign y_more = (9'(idx_q[1]) + 9'd1) < pts_q[1];
  assign x_more = (9'(idx_q[0]) + 9'd1) < pts_q[0];

  assign emit_go = (state_q == sgfa_pkg::S_EMIT) && (!out_valid_q || !out_stall_i);

  // ---------------------------------------------------------------- weight divider
  logic [sgfa_pkg::NUM_W-1:0] div_num;
  logic [sgfa_pkg::DEN_W-1:0] div_den;
  logic [7:0]                 w_nm1;
  sgfa_pkg::div_stat_t        div_stat;
  logic [sgfa_pkg::WT_W-1:0]  div_quo;

  // denominator 3(n-1), numerator k*2^F + d/2 with k = 1, 2, 4
  assign w_nm1   = 8'(pts_q[wax_q] - 9'd1);
  assign div_den = {1'b0, w_nm1, 1'b0} + {2'b00, w_nm1};
  assign div_num = (sgfa_pkg::NUM_W'(1) << (sgfa_pkg::WFRAC + 32'(wk_q)))
                 + sgfa_pkg::NUM_W'(div_den >> 1);

  sgfa_wdiv u_wdiv (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (state_q == sgfa_pkg::S_WSTART),
    .num_i   (div_num),
    .den_i   (div_den),
    .stat_o  (div_stat),
    .quo_o   (div_quo)
  );

  // ---------------------------------------------------------------- shared multiplier
  logic [31:0] mul_a, mul_b;
  logic [63:0] mul_p;

  always_comb begin
    mul_a = opnd_q[31:0];
    mul_b = {1'b0, w_q};
    case (state_q)
      sgfa_pkg::S_SQ: mul_b = opnd_q[31:0];
      sgfa_pkg::S_MH: mul_a = opnd_q[63:32];
      default: ;
    endcase
  end

  sgfa_mul u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (mul_p)
  );

  // ---------------------------------------------------------------- state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= sgfa_pkg::S_WSTART;
    end else begin
      state_q <= state_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      sgfa_pkg::S_WSTART: state_d = sgfa_pkg::S_WWAIT;
      sgfa_pkg::S_WWAIT: begin
        if (div_stat.done) begin
          state_d = (wk_q == 2'd2 && wax_q == 2'd2) ? sgfa_pkg::S_IDLE : sgfa_pkg::S_WSTART;
        end
      end
      sgfa_pkg::S_IDLE: begin
        if (in_valid_i) state_d = sgfa_pkg::S_LOAD;
      end
      sgfa_pkg::S_LOAD: begin
        state_d = (kind_sq && level_q == 2'd0) ? sgfa_pkg::S_SQ : sgfa_pkg::S_ML;
      end
      sgfa_pkg::S_SQ:   state_d = sgfa_pkg::S_SQR;
      sgfa_pkg::S_SQR:  state_d = sgfa_pkg::S_ML;
      sgfa_pkg::S_ML:   state_d = sgfa_pkg::S_MH;
      sgfa_pkg::S_MH:   state_d = sgfa_pkg::S_COMB;
      sgfa_pkg::S_COMB: state_d = sgfa_pkg::S_TERM;
      sgfa_pkg::S_TERM: state_d = sgfa_pkg::S_ACC;
      sgfa_pkg::S_ACC: begin
        state_d = (job_q == 3'd5) ? sgfa_pkg::S_LEVEL : sgfa_pkg::S_LOAD;
      end
      sgfa_pkg::S_LEVEL: begin
        unique case (level_q)
          2'd0:    state_d = z_more ? sgfa_pkg::S_IDLE : sgfa_pkg::S_LOAD;
          2'd1:    state_d = y_more ? sgfa_pkg::S_IDLE : sgfa_pkg::S_LOAD;
          default: state_d = x_more ? sgfa_pkg::S_IDLE : sgfa_pkg::S_EMIT;
        endcase
      end
      sgfa_pkg::S_EMIT: begin
        if (emit_go) state_d = sgfa_pkg::S_IDLE;
      end
      default: state_d = sgfa_pkg::S_WSTART;
    endcase
    if (cfg_hit) state_d = sgfa_pkg::S_WSTART;
  end

  assign in_stall_o = (state_q != sgfa_pkg::S_IDLE);

  // ---------------------------------------------------------------- operand select
  logic [1:0]               w_ax;
  logic [3:0]               w_base;
  logic [sgfa_pkg::PTS_W-1:0] w_n;
  logic [sgfa_pkg::IDX_W-1:0] w_i;
  logic [sgfa_pkg::WT_W-1:0]  w_sel;
  logic signed [AW-1:0]     src_s;
  logic [AW-1:0]            src_u, abs_s;

  always_comb begin
    w_ax   = 2'd2 - level_q;
    w_base = {1'b0, w_ax, 1'b0} + {2'b00, w_ax};
    w_n    = pts_q[w_ax];
    w_i    = idx_q[w_ax];
    if (w_n <= 9'd1) begin
      w_sel = sgfa_pkg::WT_W'(1) << sgfa_pkg::WFRAC;
    end else if (w_n == 9'd2) begin
      w_sel = sgfa_pkg::WT_W'(1) << (sgfa_pkg::WFRAC - 1);
    end else if (w_i == '0 || 9'(w_i) == w_n - 9'd1) begin
      w_sel = wt_q[w_base];
    end else if (!w_i[0]) begin
      w_sel = wt_q[w_base + 4'd1];
    end else begin
      w_sel = wt_q[w_base + 4'd2];
    end

    case (level_q)
      2'd0: begin
        src_s = {{(AW - sgfa_pkg::SMP_W){smp_q[comp][sgfa_pkg::SMP_W-1]}}, smp_q[comp]};
        src_u = row_sq_q[comp];
      end
      2'd1: begin
        src_s = row_sum_q[comp];
        src_u = row_sq_q[comp];
      end
      default: begin
        src_s = plane_sum_q[comp];
        src_u = plane_sq_q[comp];
      end
    endcase
    abs_s = src_s[AW-1] ? AW'(-src_s) : src_s;
  end

  // ---------------------------------------------------------------- rounding and sign
  logic [AW-1:0] rnd_mag, term_d;

  always_comb begin
    rnd_mag = (prod_q[95:94] != 2'b00) ? '1 : prod_q[93:30];
    if (!kind_sq && rnd_mag[AW-1]) rnd_mag = {1'b0, {(AW - 1){1'b1}}};
    term_d = neg_q ? AW'(-rnd_mag) : rnd_mag;
  end

  // ---------------------------------------------------------------- saturating accumulate
  logic signed [AW-1:0] acc_s, acc_s_new;
  logic [AW-1:0]        acc_u, acc_u_new;
  logic [AW:0]          sum_s, sum_u;

  always_comb begin
    case (level_q)
      2'd0: begin
        acc_s = row_sum_q[comp];
        acc_u = row_sq_q[comp];
      end
      2'd1: begin
        acc_s = plane_sum_q[comp];
        acc_u = plane_sq_q[comp];
      end
      default: begin
        acc_s = vol_sum_q[comp];
        acc_u = vol_sq_q[comp];
      end
    endcase
    sum_s = {acc_s[AW-1], acc_s} + {term_q[AW-1], term_q};
    sum_u = {1'b0, acc_u} + {1'b0, term_q};
    if (sum_s[AW] != sum_s[AW-1]) begin
      acc_s_new = sum_s[AW] ? {1'b1, {(AW - 1){1'b0}}} : {1'b0, {(AW - 1){1'b1}}};
    end else begin
      acc_s_new = sum_s[AW-1:0];
    end
    acc_u_new = sum_u[AW] ? '1 : sum_u[AW-1:0];
  end

  // output saturation helpers
  function automatic logic [sgfa_pkg::SMP_W-1:0] sat32(input logic signed [AW-1:0] v);
    logic hi_ok;
    hi_ok = (v[AW-1:sgfa_pkg::SMP_W-1] == '0) || (v[AW-1:sgfa_pkg::SMP_W-1] == '1);
    if (hi_ok) return v[sgfa_pkg::SMP_W-1:0];
    return v[AW-1] ? {1'b1, {(sgfa_pkg::SMP_W - 1){1'b0}}}
                   : {1'b0, {(sgfa_pkg::SMP_W - 1){1'b1}}};
  endfunction

  function automatic logic [sgfa_pkg::SQ_OUT_W-1:0] sat48(input logic [AW-1:0] v);
    return (v[AW-1:sgfa_pkg::SQ_OUT_W] != '0) ? '1 : v[sgfa_pkg::SQ_OUT_W-1:0];
  endfunction

  // clamp a written point count into 1..MAX_POINTS
  function automatic logic [sgfa_pkg::PTS_W-1:0] clamp_pts(
    input logic [sgfa_pkg::PTS_W-1:0] v
  );
    if (v == '0) return sgfa_pkg::PTS_W'(1);
    if (v > sgfa_pkg::PTS_W'(sgfa_pkg::MAX_POINTS)) return sgfa_pkg::PTS_W'(sgfa_pkg::MAX_POINTS);
    return v;
  endfunction

  // ---------------------------------------------------------------- control and sums
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < 3; k++) begin
        pts_q[k]       <= sgfa_pkg::PTS_W'(1);
        idx_q[k]       <= '0;
        row_sum_q[k]   <= '0;
        plane_sum_q[k] <= '0;
        vol_sum_q[k]   <= '0;
        row_sq_q[k]    <= '0;
        plane_sq_q[k]  <= '0;
        vol_sq_q[k]    <= '0;
      end
      first_q     <= '0;
      last_q      <= '0;
      level_q     <= '0;
      job_q       <= '0;
      wax_q       <= '0;
      wk_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_valid_q && !out_stall_i) out_valid_q <= 1'b0;

      case (state_q)
        // weight cache fill order: axis, then k
        sgfa_pkg::S_WWAIT: begin
          if (div_stat.done) begin
            if (wk_q == 2'd2) begin
              wk_q  <= '0;
              wax_q <= wax_q + 2'd1;
            end else begin
              wk_q <= wk_q + 2'd1;
            end
          end
        end
        sgfa_pkg::S_IDLE: begin
          level_q <= '0;
          job_q   <= '0;
        end
        sgfa_pkg::S_ACC: begin
          if (kind_sq) begin
            case (level_q)
              2'd0:    row_sq_q[comp]   <= acc_u_new;
              2'd1:    plane_sq_q[comp] <= acc_u_new;
              default: vol_sq_q[comp]   <= acc_u_new;
            endcase
          end else begin
            case (level_q)
              2'd0:    row_sum_q[comp]   <= acc_s_new;
              2'd1:    plane_sum_q[comp] <= acc_s_new;
              default: vol_sum_q[comp]   <= acc_s_new;
            endcase
          end
          job_q <= (job_q == 3'd5) ? 3'd0 : job_q + 3'd1;
        end
        sgfa_pkg::S_LEVEL: begin
          case (level_q)
            2'd0: begin
              if (z_more) begin
                idx_q[2] <= idx_q[2] + 1'b1;
              end else begin
                idx_q[2] <= '0;
                level_q  <= 2'd1;
              end
            end
            2'd1: begin
              for (int k = 0; k < 3; k++) begin
                row_sum_q[k] <= '0;
                row_sq_q[k]  <= '0;
              end
              if (y_more) begin
                idx_q[1] <= idx_q[1] + 1'b1;
              end else begin
                idx_q[1] <= '0;
                level_q  <= 2'd2;
                if (idx_q[0] == '0) first_q <= plane_sum_q[0];
                if (!x_more) last_q <= plane_sum_q[0];
              end
            end
            default: begin
              for (int k = 0; k < 3; k++) begin
                plane_sum_q[k] <= '0;
                plane_sq_q[k]  <= '0;
              end
              if (x_more) idx_q[0] <= idx_q[0] + 1'b1;
            end
          endcase
        end
        sgfa_pkg::S_EMIT: begin
          if (emit_go) begin
            out_valid_q <= 1'b1;
            for (int k = 0; k < 3; k++) begin
              idx_q[k]     <= '0;
              vol_sum_q[k] <= '0;
              vol_sq_q[k]  <= '0;
            end
            first_q <= '0;
            last_q  <= '0;
          end
        end
        default: ;
      endcase

      // register write restarts the grid and the weight cache
      if (cfg_hit) begin
        pts_q[cfg_idx_i] <= clamp_pts(cfg_data_i);
        for (int k = 0; k < 3; k++) begin
          idx_q[k]       <= '0;
          row_sum_q[k]   <= '0;
          plane_sum_q[k] <= '0;
          vol_sum_q[k]   <= '0;
          row_sq_q[k]    <= '0;
          plane_sq_q[k]  <= '0;
          vol_sq_q[k]    <= '0;
        end
        first_q <= '0;
        last_q  <= '0;
        wax_q   <= '0;
        wk_q    <= '0;
      end
    end
  end

  // ---------------------------------------------------------------- datapath registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      sgfa_pkg::S_WWAIT: begin
        if (div_stat.done) wt_q[{1'b0, wax_q, 1'b0} + {2'b00, wax_q} + {2'b00, wk_q}] <= div_quo;
      end
      sgfa_pkg::S_IDLE: begin
        smp_q[0] <= in_data_i.sample_x;
        smp_q[1] <= in_data_i.sample_y;
        smp_q[2] <= in_data_i.sample_z;
      end
      sgfa_pkg::S_LOAD: begin
        w_q <= w_sel;
        if (kind_sq) begin
          opnd_q <= (level_q == 2'd0) ? abs_s : src_u;
          neg_q  <= 1'b0;
        end else begin
          opnd_q <= abs_s;
          neg_q  <= src_s[AW-1];
        end
      end
      // square rounded from Q32.32 to Q32.16
      sgfa_pkg::S_SQR:  opnd_q <= AW'((mul_p + 64'h8000) >> 16);
      sgfa_pkg::S_MH:   pl_q   <= mul_p;
      sgfa_pkg::S_COMB: begin
        prod_q <= {mul_p, 32'b0} + {32'b0, pl_q}
                + 96'(64'd1 << (sgfa_pkg::WFRAC - 1));
      end
      sgfa_pkg::S_TERM: term_q <= term_d;
      sgfa_pkg::S_EMIT: begin
        if (emit_go) begin
          out_q.mean_bx        <= sat32(vol_sum_q[0]);
          out_q.mean_by        <= sat32(vol_sum_q[1]);
          out_q.mean_bz        <= sat32(vol_sum_q[2]);
          out_q.meansq_bx      <= sat48(vol_sq_q[0]);
          out_q.meansq_by      <= sat48(vol_sq_q[1]);
          out_q.meansq_bz      <= sat48(vol_sq_q[2]);
          out_q.first_plane_bx <= sat32(first_q);
          out_q.last_plane_bx  <= sat32(last_q);
        end
      end
      default: ;
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // ---------------------------------------------------------------- assertions
  a_idx_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (9'(idx_q[0]) < pts_q[0]) && (9'(idx_q[1]) < pts_q[1]) && (9'(idx_q[2]) < pts_q[2]))
    else $error("grid index beyond point count");

  a_div_active: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == sgfa_pkg::S_WWAIT) |-> (div_stat.busy || div_stat.done))
    else $error("waiting on an idle weight divider");

  a_emit_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit_go |=> out_valid_q)
    else $error("grid result not presented");

  a_job_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    job_q <= 3'd5)
    else $error("job counter out of range");

endmodule

`default_nettype wire

>>> hw/rtl/sgfa_mul.sv
// Shared 32x32 unsigned multiplier with registered product.
`timescale 1ns / 1ps
`default_nettype none

module sgfa_mul (
  input  logic        clk_i,
  input  logic [31:0] a_i,
  input  logic [31:0] b_i,
  output logic [63:0] p_o
);

  logic [63:0] p_q;

  // product is registered and available in the cycle after operands are presented
  always_ff @(posedge clk_i) begin
    p_q <= 64'(a_i) * 64'(b_i);
  end

  assign p_o = p_q;

endmodule

`default_nettype wire

>>> hw/rtl/sgfa_wdiv.sv
// Bit-serial restoring divider for the axis weight cache.
`timescale 1ns / 1ps
`default_nettype none

module sgfa_wdiv (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  input  logic [sgfa_pkg::NUM_W-1:0]      num_i,
  input  logic [sgfa_pkg::DEN_W-1:0]      den_i,
  output sgfa_pkg::div_stat_t             stat_o,
  output logic [sgfa_pkg::WT_W-1:0]       quo_o
);

  logic                         busy_q;
  logic                         done_q;
  logic [sgfa_pkg::CNT_W-1:0]   cnt_q;
  logic [sgfa_pkg::DEN_W-1:0]   rem_q;
  logic [sgfa_pkg::DEN_W-1:0]   den_q;
  logic [sgfa_pkg::NUM_W-1:0]   num_q;
  logic [sgfa_pkg::NUM_W-1:0]   quo_q;
  logic [sgfa_pkg::DEN_W:0]     trial;
  logic [sgfa_pkg::DEN_W:0]     diff;
  logic                         ge;

  // one quotient bit per cycle
  assign trial = {rem_q, num_q[sgfa_pkg::NUM_W-1]};
  assign diff  = trial - {1'b0, den_q};
  assign ge    = trial >= {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= sgfa_pkg::CNT_W'(sgfa_pkg::NUM_W);
    end else if (busy_q) begin
      cnt_q <= cnt_q - 1'b1;
      if (cnt_q == sgfa_pkg::CNT_W'(1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      den_q <= den_i;
      num_q <= num_i;
      quo_q <= '0;
    end else if (busy_q) begin
      rem_q <= ge ? diff[sgfa_pkg::DEN_W-1:0] : trial[sgfa_pkg::DEN_W-1:0];
      num_q <= {num_q[sgfa_pkg::NUM_W-2:0], 1'b0};
      quo_q <= {quo_q[sgfa_pkg::NUM_W-2:0], ge};
    end
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign quo_o       = quo_q[sgfa_pkg::WT_W-1:0];

endmodule

`default_nettype wire
